// File: rtl/pvw_pkg.sv
// Shared types and constants for the packed variable-width integer array.
package pvw_pkg;

  localparam int WORD_BITS      = 64;
  localparam int WORD_COUNT_DEF = 1024;
  localparam int POS_W          = 24;
  localparam int WIDTH_W        = 7;
  localparam int COUNT_W        = 17;
  localparam int INDEX_W        = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_WIDE  = 2'd2;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [INDEX_W-1:0]   elem_index;
    logic [WORD_BITS-1:0] write_value;
  } pvw_req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] read_value;
    logic [1:0]           status;
  } pvw_result_t;

endpackage

// File: rtl/pvw_ram.sv
// Generic single-port RAM with registered read data.
module pvw_ram
  import pvw_pkg::*;
#(
  parameter int WIDTH = WORD_BITS,
  parameter int DEPTH = WORD_COUNT_DEF
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                             wdata,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/packed_variable_width_int_array.sv
// Packed variable-width integer array: elements of 1..64 bits packed into 64-bit words.
// Result strobe follows S_ITEM0 when the field sits in one word, S_ITEM1 for a read
// and S_ITEM2 for a write that straddles two words; busy covers the item.
// No new item is taken until the previous one is through the single-port word memory.
// Reset clears control state only: count is zero, so no stored bit is visible; growing
// the count clears each newly covered word via S_CLR_WR with busy held high.
module packed_variable_width_int_array
  import pvw_pkg::*;
#(
  parameter int WORD_COUNT = WORD_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  pvw_req_t              req,
  output logic                  busy,
  output logic                  done,
  output pvw_result_t           result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam logic [POS_W-1:0] CAP_BITS = POS_W'(WORD_COUNT * WORD_BITS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ITEM0  = 3'd1;
  localparam logic [2:0] S_ITEM1  = 3'd2;
  localparam logic [2:0] S_ITEM2  = 3'd3;
  localparam logic [2:0] S_CLR_WR = 3'd4;

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [WIDTH_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    m = (n >= 7'd64) ? '1 : ((64'd1 << n) - 64'd1);
    return m;
  endfunction

  logic [2:0]           state;
  logic [WIDTH_W-1:0]   width;
  logic [COUNT_W-1:0]   count;
  logic [POS_W-1:0]     count_bits;
  logic [POS_W-1:0]     sweep_lo;
  logic [POS_W-1:0]     sweep_hi;
  logic [POS_W-1:0]     clr_start;
  pvw_req_t             req_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [5:0]           off_q;
  logic [5:0]           lo_n_q;
  logic                 straddle_q;
  logic [1:0]           err_q;
  logic [WORD_BITS-1:0] hold_word;

  // config side
  logic [COUNT_W-1:0]   new_count;
  logic [POS_W-1:0]     new_bits;
  logic [POS_W-1:0]     new_hi;
  logic                 grow;
  logic [POS_W-1:0]     base_lo;
  logic                 active_after;
  logic                 pending;
  logic [POS_W-1:0]     sweep_lo_next;

  // accept side
  logic                 accept;
  logic [POS_W-1:0]     acc_pos;
  logic [POS_W-1:0]     acc_end;
  logic                 acc_range;
  logic                 acc_wide;
  logic [WIDTH_W-1:0]   acc_sum;
  logic [ADDR_W-1:0]    acc_addr;
  logic                 done_next;

  // memory port
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] rdata;

  // field datapath
  logic [WORD_BITS-1:0] fmask;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] ns_read;
  logic [WORD_BITS-1:0] ns_write;
  logic [WORD_BITS-1:0] st_read;
  logic [WORD_BITS-1:0] w0_new;
  logic [WORD_BITS-1:0] w1_new;

  assign new_count = cfg_data[COUNT_W-1:0];
  assign new_bits  = POS_W'(new_count) * POS_W'(width);
  assign new_hi    = (new_bits > CAP_BITS) ? CAP_BITS : new_bits;
  assign grow      = cfg_we && (cfg_index == REG_ELEMENT_COUNT) && (new_count > count);

  // after a word is cleared the sweep moves to the next word, unless a grow pulled it lower
  assign base_lo = ((state == S_CLR_WR) && (sweep_lo == clr_start))
                 ? {clr_start[POS_W-1:6] + (POS_W-6)'(1), 6'd0} : sweep_lo;
  assign active_after = base_lo < sweep_hi;
  assign pending      = sweep_lo < sweep_hi;

  // bits past the current count are never visible, so the span may be widened
  assign sweep_lo_next = !grow ? base_lo
                       : (!active_after ? count_bits
                       : ((base_lo < count_bits) ? base_lo : count_bits));

  assign busy   = (state != S_IDLE) || pending || cfg_we;
  assign accept = start && !busy;

  assign acc_pos   = POS_W'(req.elem_index) * POS_W'(width);
  assign acc_end   = acc_pos + POS_W'(width);
  assign acc_range = ({1'b0, req.elem_index} >= count) || (acc_end > CAP_BITS);
  assign acc_wide  = (req.req_type == REQ_WRITE) &&
                     ((req.write_value & low_mask(width)) != req.write_value);
  assign acc_sum   = {1'b0, acc_pos[5:0]} + width;
  assign acc_addr  = acc_pos[6 +: ADDR_W];

  assign done_next = ((state == S_ITEM0) && ((err_q != STATUS_OK) || !straddle_q))
                   || ((state == S_ITEM1) && (req_q.req_type == REQ_READ))
                   || (state == S_ITEM2);

  assign fmask    = low_mask(width);
  assign lo_mask  = low_mask({1'b0, lo_n_q});
  assign ns_read  = (rdata >> off_q) & fmask;
  assign ns_write = (rdata & ~(fmask << off_q)) | (req_q.write_value << off_q);
  assign st_read  = ((hold_word >> off_q) << lo_n_q) | (rdata & lo_mask);
  assign w0_new   = (hold_word & low_mask({1'b0, off_q}))
                  | ((req_q.write_value >> lo_n_q) << off_q);
  assign w1_new   = (rdata & ~lo_mask) | (req_q.write_value & lo_mask);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = acc_addr;
    mem_wdata = ns_write;
    unique case (state)
      S_IDLE: begin
        if (pending) begin
          mem_addr = sweep_lo[6 +: ADDR_W];
        end
      end
      S_ITEM0: begin
        mem_addr = addr_q;
        if (err_q == STATUS_OK) begin
          if (straddle_q) begin
            mem_addr = addr_q + ADDR_W'(1);
          end else if (req_q.req_type == REQ_WRITE) begin
            mem_we = 1'b1;
          end
        end
      end
      S_ITEM1: begin
        mem_addr  = addr_q;
        mem_wdata = w0_new;
        mem_we    = (req_q.req_type == REQ_WRITE);
      end
      S_ITEM2: begin
        mem_addr  = addr_q + ADDR_W'(1);
        mem_wdata = hold_word;
        mem_we    = 1'b1;
      end
      S_CLR_WR: begin
        mem_addr  = clr_start[6 +: ADDR_W];
        mem_wdata = rdata & low_mask({1'b0, clr_start[5:0]});
        mem_we    = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  pvw_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORD_COUNT)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      width      <= WIDTH_W'(1);
      count      <= '0;
      count_bits <= '0;
      sweep_lo   <= '0;
      sweep_hi   <= '0;
      done       <= 1'b0;
    end else begin
      done     <= done_next;
      sweep_lo <= sweep_lo_next;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_ELEMENT_WIDTH: begin
            if ((count == '0) && (cfg_data[WIDTH_W-1:0] >= 7'd1) &&
                (cfg_data[WIDTH_W-1:0] <= 7'd64)) begin
              width <= cfg_data[WIDTH_W-1:0];
            end
          end
          REG_ELEMENT_COUNT: begin
            count      <= new_count;
            count_bits <= new_bits;
            if (grow) begin
              if (active_after) begin
                sweep_hi <= (sweep_hi > new_hi) ? sweep_hi : new_hi;
              end else begin
                sweep_hi <= new_hi;
              end
            end
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (pending) begin
            clr_start <= sweep_lo;
            state     <= S_CLR_WR;
          end else if (accept) begin
            req_q      <= req;
            addr_q     <= acc_addr;
            off_q      <= acc_pos[5:0];
            lo_n_q     <= acc_sum[5:0];
            straddle_q <= acc_sum > 7'd64;
            err_q      <= acc_range ? STATUS_RANGE : (acc_wide ? STATUS_WIDE : STATUS_OK);
            state      <= S_ITEM0;
          end
        end
        S_ITEM0: begin
          if (err_q != STATUS_OK) begin
            result.read_value <= '0;
            result.status     <= err_q;
            state             <= S_IDLE;
          end else if (straddle_q) begin
            hold_word <= rdata;
            state     <= S_ITEM1;
          end else begin
            result.read_value <= (req_q.req_type == REQ_WRITE) ? '0 : ns_read;
            result.status     <= STATUS_OK;
            state             <= S_IDLE;
          end
        end
        S_ITEM1: begin
          if (req_q.req_type == REQ_READ) begin
            result.read_value <= st_read;
            result.status     <= STATUS_OK;
            state             <= S_IDLE;
          end else begin
            hold_word <= w1_new;
            state     <= S_ITEM2;
          end
        end
        S_ITEM2: begin
          result.read_value <= '0;
          result.status     <= STATUS_OK;
          state             <= S_IDLE;
        end
        S_CLR_WR: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/pvw_checker.sv
// Port-level checks for the packed variable-width integer array, bound to the top level.
module pvw_checker
  import pvw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input pvw_result_t result,
  input logic        cfg_we
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted beat not followed by a busy cycle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without preceding work");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != STATUS_OK)) |-> (result.read_value == '0))
    else $error("rejected request returned data");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.status == STATUS_OK) || (result.status == STATUS_RANGE) ||
              (result.status == STATUS_WIDE)))
    else $error("undefined status code");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> busy)
    else $error("request could be taken alongside a register write");

endmodule

bind packed_variable_width_int_array pvw_checker u_pvw_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result),
  .cfg_we(cfg_we)
);
